>>> hw/rtl/ssvm_pkg.sv
// Package: opcodes, fault codes and decode helpers for the stack bytecode core.
package ssvm_pkg;

  localparam int unsigned STACK_WORDS_DEF = 256;
  localparam logic [31:0] END_ADDRESS_DEF = 32'hFFFF_FFFF;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_PUSH = 5'd1, OP_PUSHA = 5'd2, OP_TOSS = 5'd3, OP_POPA = 5'd4,
    OP_PUSHW = 5'd5, OP_RET = 5'd6, OP_JMP = 5'd7, OP_AND = 5'd8, OP_OR = 5'd9,
    OP_XOR = 5'd10, OP_NOT = 5'd11, OP_ADD = 5'd12, OP_SUB = 5'd13, OP_MUL = 5'd14,
    OP_DIV = 5'd15, OP_INC = 5'd16, OP_DEC = 5'd17, OP_EQ = 5'd18, OP_GT = 5'd19,
    OP_LT = 5'd20, OP_GE = 5'd21, OP_LE = 5'd22, OP_JS = 5'd23, OP_JC = 5'd24,
    OP_LDA = 5'd25, OP_START = 5'd26
  } op_t;

  localparam logic [2:0] FLT_OK = 3'd0;
  localparam logic [2:0] FLT_OVERFLOW = 3'd1;
  localparam logic [2:0] FLT_UNDERFLOW = 3'd2;
  localparam logic [2:0] FLT_DIV_ZERO = 3'd3;
  localparam logic [2:0] FLT_BAD_OP = 3'd4;
  localparam logic [2:0] FLT_IP_RANGE = 3'd5;

  // classified item handed from front to back
  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] immediate;
    logic [2:0]  fetch_len;
    logic [1:0]  npop;
    logic        npush;
    logic        bad_op;
  } dec_item_t;

  function automatic logic [2:0] fetch_length(input logic [4:0] op);
    logic [2:0] len;
    case (op)
      OP_PUSH, OP_JMP, OP_JS, OP_JC, OP_LDA: len = 3'd5;
      OP_PUSHW: len = 3'd3;
      OP_START: len = 3'd0;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] pop_count(input logic [4:0] op);
    logic [1:0] n;
    case (op)
      OP_TOSS, OP_POPA, OP_RET, OP_NOT, OP_INC, OP_DEC: n = 2'd1;
      OP_AND, OP_OR, OP_XOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
      OP_EQ, OP_GT, OP_LT, OP_GE, OP_LE: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic push_count(input logic [4:0] op);
    logic n;
    case (op)
      OP_PUSH, OP_PUSHA, OP_PUSHW, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_ADD, OP_SUB,
      OP_MUL, OP_DIV, OP_INC, OP_DEC, OP_START: n = 1'b1;
      default: n = 1'b0;
    endcase
    return n;
  endfunction

endpackage

>>> hw/rtl/ssvm_front.sv
// Front end: accepts items, classifies them and queues them for execution.
module ssvm_front
  import ssvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [4:0]  op,
  input  logic [31:0] immediate,
  output logic        q_valid,
  input  logic        q_ready,
  output dec_item_t   q_item
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);

  dec_item_t       queue [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [QW:0]     count;
  logic            push;
  logic            pop;
  dec_item_t       dec;

  always_comb begin
    dec.op = op;
    dec.immediate = immediate;
    dec.fetch_len = fetch_length(op);
    dec.npop = pop_count(op);
    dec.npush = push_count(op);
    dec.bad_op = (op > OP_START);
  end

  assign ready = (count != (QW+1)'(QUEUE_DEPTH));
  assign push = valid && ready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_item = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

endmodule

>>> hw/rtl/ssvm_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module ssvm_divider
  import ssvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/ssvm_back.sv
// Back end: stack memory, architectural registers and execution sequencer.
module ssvm_back
  import ssvm_pkg::*;
#(
  parameter int unsigned STACK_WORDS = STACK_WORDS_DEF,
  parameter logic [31:0] END_ADDRESS = END_ADDRESS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] code_length,
  input  logic        q_valid,
  output logic        q_ready,
  input  dec_item_t   q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_ip,
  output logic        is_running,
  output logic [31:0] top_value,
  output logic [31:0] accumulator,
  output logic        cmp_flag,
  output logic [2:0]  fault
);

  localparam int unsigned AW = $clog2(STACK_WORDS);
  localparam int unsigned LW = $clog2(STACK_WORDS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_TOP  = 5'b10000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [31:0]     mem [STACK_WORDS];
  logic [LW-1:0]   level;
  logic [31:0]     acc_reg;
  logic            flag_reg;
  logic [31:0]     pc_reg;
  logic            run_bit;
  logic [31:0]     top_reg;
  dec_item_t       cur;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [31:0]     wr_data;
  logic [31:0]     t;
  logic [31:0]     s;
  logic [32:0]     fetched;
  logic [2:0]      flt;
  logic [31:0]     res;
  logic [31:0]     ip_new;
  logic [31:0]     acc_new;
  logic            flag_new;
  logic            run_new;
  logic [LW-1:0]   level_pop;
  logic [LW:0]     level_after;
  logic            div_start;
  logic            div_done;
  logic [31:0]     div_q;
  logic [31:0]     mul_res;

  // top is kept in top_reg; second entry read from memory
  assign t = top_reg;
  assign s = rd_data;

  ssvm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (t),
    .divisor  (s),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign q_ready = (state == ST_IDLE) && !out_valid;
  assign fetched = {1'b0, pc_reg} + 33'(cur.fetch_len);
  assign level_pop = level - LW'(cur.npop);
  assign level_after = (LW+1)'(level_pop) + (LW+1)'(cur.npush);
  assign mul_res = t * s;

  always_comb begin
    if (cur.op != OP_START && fetched > {1'b0, code_length}) begin
      flt = FLT_IP_RANGE;
    end else if (cur.bad_op) begin
      flt = FLT_BAD_OP;
    end else if (level < LW'(cur.npop)) begin
      flt = FLT_UNDERFLOW;
    end else if (level_after > (LW+1)'(STACK_WORDS)) begin
      flt = FLT_OVERFLOW;
    end else if (cur.op == OP_DIV && s == 32'd0) begin
      flt = FLT_DIV_ZERO;
    end else begin
      flt = FLT_OK;
    end
  end

  always_comb begin
    res = '0;
    ip_new = fetched[31:0];
    acc_new = acc_reg;
    flag_new = flag_reg;
    run_new = run_bit;
    case (cur.op)
      OP_PUSH:  res = cur.immediate;
      OP_PUSHA: res = acc_reg;
      OP_POPA:  acc_new = t;
      OP_PUSHW: res = {16'd0, cur.immediate[15:0]};
      OP_RET: begin
        ip_new = t;
        if (t == END_ADDRESS) begin
          run_new = 1'b0;
        end
      end
      OP_JMP:   ip_new = cur.immediate;
      OP_AND:   res = t & s;
      OP_OR:    res = t | s;
      OP_XOR:   res = t ^ s;
      OP_NOT:   res = ~t;
      OP_ADD:   res = t + s;
      OP_SUB:   res = s - t;
      OP_MUL:   res = mul_res;
      OP_DIV:   res = div_q;
      OP_INC:   res = t + 32'd1;
      OP_DEC:   res = t - 32'd1;
      OP_EQ:    flag_new = (t == s);
      OP_GT:    flag_new = (s > t);
      OP_LT:    flag_new = (t < s);
      OP_GE:    flag_new = (t >= s);
      OP_LE:    flag_new = (t <= s);
      OP_JS:    if (flag_reg) ip_new = cur.immediate;
      OP_JC:    if (!flag_reg) ip_new = cur.immediate;
      OP_LDA:   acc_new = cur.immediate;
      OP_START: begin
        res = END_ADDRESS;
        ip_new = cur.immediate;
        run_new = 1'b1;
      end
      default: ;
    endcase
  end

  logic commit;
  assign commit = ((state == ST_EXEC) && !(cur.op == OP_DIV && flt == FLT_OK)) ||
                  ((state == ST_DIV) && div_done);
  assign div_start = (state == ST_EXEC) && cur.op == OP_DIV && flt == FLT_OK;

  // stack address for reads: second entry up to EXEC, new top after a pop issued in EXEC;
  // div keeps the second entry so the divisor stays put
  always_comb begin
    wr_en = 1'b0;
    wr_addr = AW'(level_pop);
    wr_data = res;
    rd_addr = AW'(level - LW'(2));
    if (state == ST_EXEC && cur.op != OP_DIV) begin
      rd_addr = AW'(level_pop - LW'(1));
    end
    if (commit && flt == FLT_OK && cur.npush) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid && q_ready) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (div_start) begin
          state_next = ST_DIV;
        end else if (flt == FLT_OK && cur.npop != 2'd0 && !cur.npush) begin
          state_next = ST_TOP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: if (div_done) state_next = ST_IDLE;
      ST_TOP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic result_now;
  assign result_now = (commit && !(flt == FLT_OK && cur.npop != 2'd0 && !cur.npush))
                      || state == ST_TOP;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_ready) begin
      cur <= q_item;
    end
    if (state == ST_TOP) begin
      top_reg <= (level == '0) ? 32'd0 : rd_data;
    end else if (commit && flt == FLT_OK) begin
      if (cur.npush) begin
        top_reg <= res;
      end
    end
    if (result_now) begin
      fault <= (state == ST_TOP) ? FLT_OK : flt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      level <= '0;
      acc_reg <= '0;
      flag_reg <= 1'b0;
      pc_reg <= '0;
      run_bit <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (result_now) begin
        out_valid <= 1'b1;
      end
      if (commit && flt == FLT_OK) begin
        level <= LW'(level_after);
        pc_reg <= ip_new;
        acc_reg <= acc_new;
        flag_reg <= flag_new;
        run_bit <= run_new;
      end
    end
  end

  assign next_ip = pc_reg;
  assign is_running = run_bit;
  assign top_value = (level == '0) ? 32'd0 : top_reg;
  assign accumulator = acc_reg;
  assign cmp_flag = flag_reg;

endmodule

>>> hw/rtl/script_stack_vm_core.sv
// Top level of the stack bytecode execution core.
//
//  channel    dir  handshake            payload
//  in         in   valid / ready        op, immediate
//  out        out  out_valid/out_ready  next_ip .. fault
//  cfg        in   cfg_valid/cfg_ready  cfg_data (code_length)
//
// The back end holds a result after taking an item, through stack read, execute and result;
// ops that pop without pushing and do not fault also pass a state that refetches the new top from the stack RAM.
// div also waits on the bit-serial divider.
// The back end takes the next item the cycle after its result is taken, so it works on one
// item at a time. The two-entry queue lets the front accept meanwhile.
// Reset is synchronous; the stack RAM is not cleared.
module script_stack_vm_core
  import ssvm_pkg::*;
#(
  parameter int unsigned STACK_WORDS = STACK_WORDS_DEF,
  parameter logic [31:0] END_ADDRESS = END_ADDRESS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [4:0]  op,
  input  logic [31:0] immediate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_ip,
  output logic        is_running,
  output logic [31:0] top_value,
  output logic [31:0] accumulator,
  output logic        cmp_flag,
  output logic [2:0]  fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] code_length;
  logic        q_valid;
  logic        q_ready;
  dec_item_t   q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      code_length <= cfg_data;
    end
  end

  ssvm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .valid     (valid),
    .ready     (ready),
    .op        (op),
    .immediate (immediate),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  ssvm_back #(
    .STACK_WORDS (STACK_WORDS),
    .END_ADDRESS (END_ADDRESS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .code_length (code_length),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .next_ip     (next_ip),
    .is_running  (is_running),
    .top_value   (top_value),
    .accumulator (accumulator),
    .cmp_flag    (cmp_flag),
    .fault       (fault)
  );

`ifndef SYNTHESIS
  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fault <= FLT_IP_RANGE) else $error("fault code out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_ip) && $stable(fault))
    else $error("result changed while stalled");
  a_fault_keeps_ip: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && fault != FLT_OK |-> $stable(next_ip) && $stable(accumulator))
    else $error("faulting item changed state");
`endif

endmodule
